// File: sv/name_keyed_byte_descrambler_defines.svh
// Assertion macros shared by the descrambler checkers.
// Included by bare file name; no other dependencies.
`ifndef NAME_KEYED_BYTE_DESCRAMBLER_DEFINES_SVH
`define NAME_KEYED_BYTE_DESCRAMBLER_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define NKBD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("descrambler check failed");

// Clocked property that is also checked during reset.
`define NKBD_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("descrambler reset check failed");

`endif

// File: sv/nkbd_pkg.sv
// Shared types, codes and helpers of the name-keyed byte descrambler.
// No dependencies; imported by the key pipe, the top level and the checker.
package nkbd_pkg;

	localparam int ENCRYPTED_SPAN_DEF = 4096;
	localparam int NAME_LEN_MAX_DEF   = 4095;
	localparam int CFG_IDX_W          = 3;

	localparam logic [7:0] NAME_KEY_MULT = 8'hfc;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_NAME  = 2'd2,
		FUNC_DATA  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NAME_KEY  = 3'd0,
		REG_DATA_SEED = 3'd1,
		REG_HDR_ONE   = 3'd2,
		REG_HDR_TWO   = 3'd3,
		REG_DEC_EN    = 3'd4
	} cfg_reg_t;

	// Operands of the per-file data key, all reduced to one byte.
	typedef struct packed {
		logic [7:0] seed;
		logic [7:0] name_sum;
		logic [7:0] name_pos;
		logic [7:0] hkey_one;
		logic [7:0] hkey_two;
		logic [7:0] size_byte;
	} key_in_t;

	function automatic logic [7:0] byte_sum(input logic [31:0] w);
		return w[7:0] + w[15:8] + w[23:16] + w[31:24];
	endfunction

endpackage

// File: sv/nkbd_tbl_mem.sv
// 256 x 8 substitution table: one write port, one read port, registered read.
// No dependencies.
module nkbd_tbl_mem (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic       re,
	input  logic [7:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem_q [256];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: sv/nkbd_key_pipe.sv
// Two-stage multiply pipeline that tracks the per-file data key.
// Depends on nkbd_pkg for key_in_t.
module nkbd_key_pipe (
	input  logic              clk,
	input  nkbd_pkg::key_in_t kin,
	output logic [7:0]        key
);
	import nkbd_pkg::*;

	logic [7:0]  diff;
	logic [15:0] prod_a;
	logic [15:0] prod_h;
	logic [7:0]  sum_s2;
	logic [15:0] prod_b;
	logic [7:0]  pa_s1;
	logic [7:0]  ph_s1;
	logic [7:0]  key_s2;

	assign diff   = kin.seed - kin.name_sum;
	assign prod_a = diff * kin.name_pos;
	assign prod_h = kin.hkey_one * kin.hkey_two;
	assign sum_s2 = pa_s1 + ph_s1;
	assign prod_b = sum_s2 * kin.size_byte;

	// Recompute every cycle; only the low byte of each product matters.
	always_ff @(posedge clk) begin
		pa_s1  <= prod_a[7:0];
		ph_s1  <= prod_h[7:0];
		key_s2 <= prod_b[7:0];
	end

	assign key = key_s2;
endmodule

// File: sv/name_keyed_byte_descrambler.sv
// Name-keyed byte descrambler, top level.
// Depends on nkbd_pkg, nkbd_tbl_mem and nkbd_key_pipe.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one word per item: func selects
//    table load, file start, name byte or data byte. Loads and starts give no
//    result; name and data bytes give one result word on out_valid/out_ready.
//  - Config channel (cfg_valid/cfg_ready) writes a register by cfg_index; it is
//    always ready. The user must write it only while the block is idle; the
//    block itself does not enforce this.
//  - An accepted word passes through stage one (table read) to the output register.
//  - Throughput: one item per cycle while in_ready is high. The first data byte
//    of a file waits, after the last start, name retire or config write, for the
//    key multiply pipeline, and for an in-flight name word to leave stage one;
//    this happens once per file, and the wait grows while the receiver stalls.
//  - Reset clears all counters, the per-file state and the registers
//    (decrypt enable comes up set). The table is not cleared; load every entry
//    that data bytes will use.
//  - A stalled receiver holds the output word; stage one then holds too and
//    in_ready drops until the output is taken.
module name_keyed_byte_descrambler #(
	parameter int ENCRYPTED_SPAN = nkbd_pkg::ENCRYPTED_SPAN_DEF,
	parameter int NAME_LEN_MAX   = nkbd_pkg::NAME_LEN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nkbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [7:0]                     byte_value,
	input  logic [7:0]                     table_index,
	input  logic [31:0]                    file_index,
	input  logic [31:0]                    original_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     byte_out,
	output logic                           from_name
);
	import nkbd_pkg::*;

	localparam int NC_W   = $clog2(NAME_LEN_MAX + 1);
	localparam int DC_MAX = ENCRYPTED_SPAN + NAME_LEN_MAX;
	localparam int DC_W   = $clog2(DC_MAX + 1);
	localparam logic [NC_W-1:0] NC_SAT = NC_W'(NAME_LEN_MAX);
	localparam logic [DC_W-1:0] DC_SAT = DC_W'(DC_MAX);
	localparam logic [DC_W-1:0] SPAN   = DC_W'(ENCRYPTED_SPAN);

	// registers and per-file state
	logic [7:0]      nk_sum_q;
	logic [7:0]      seed_q;
	logic [7:0]      hk1_q;
	logic [7:0]      hk2_q;
	logic            dec_en_q;
	logic [7:0]      fidx_sum_q;
	logic [7:0]      size_q;
	logic [NC_W-1:0] name_cnt_q;
	logic [7:0]      name_sum_q;
	logic [DC_W-1:0] data_cnt_q;
	logic [7:0]      file_key_q;
	logic            key_rdy_q;
	logic            settle_q;
	logic [7:0]      idx_sum_q;

	// stage one
	logic       v_s1;
	logic       name_s1;
	logic [7:0] byte_s1;
	logic [7:0] pos_s1;
	logic [7:0] cnt_s1;
	logic       enc_s1;
	logic       new_key_s1;

	// output register
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_name_q;

	logic              in_acc;
	logic              cfg_acc;
	logic              s1_move;
	logic              key_wait;
	logic [NC_W+7:0]   nc_ext;
	logic [DC_W+7:0]   dc_ext;
	logic [DC_W-1:0]   limit;
	logic              enc;
	logic [15:0]       pos_prod;
	logic [7:0]        name_dec;
	logic [7:0]        sel_key;
	logic [7:0]        data_dec;
	logic [7:0]        tbl_rd;
	logic [7:0]        pipe_key;
	key_in_t           kin;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign s1_move   = v_s1 && (!out_v_q || out_ready);

	// The first data byte of a file waits for the key pipeline to catch up.
	assign key_wait = (func == FUNC_DATA) && !key_rdy_q && (settle_q || v_s1);
	assign in_ready = (!v_s1 || !out_v_q || out_ready) && !key_wait;

	assign nc_ext = {8'd0, name_cnt_q};
	assign dc_ext = {8'd0, data_cnt_q};
	assign limit  = SPAN + DC_W'(name_cnt_q);
	assign enc    = dec_en_q && (data_cnt_q < limit);

	assign pos_prod = pos_s1 * NAME_KEY_MULT;
	assign name_dec = byte_s1 + pos_prod[7:0] - idx_sum_q;
	assign sel_key  = new_key_s1 ? pipe_key : file_key_q;
	assign data_dec = enc_s1 ? (tbl_rd - sel_key - cnt_s1) : byte_s1;

	assign kin.seed      = seed_q;
	assign kin.name_sum  = name_sum_q;
	assign kin.name_pos  = nc_ext[7:0];
	assign kin.hkey_one  = hk1_q;
	assign kin.hkey_two  = hk2_q;
	assign kin.size_byte = size_q;

	nkbd_tbl_mem u_tbl (
		.clk   (clk),
		.we    (in_acc && (func == FUNC_LOAD)),
		.waddr (table_index),
		.wdata (byte_value),
		.re    (in_acc && (func == FUNC_DATA)),
		.raddr (byte_value),
		.rdata (tbl_rd)
	);

	nkbd_key_pipe u_key (
		.clk (clk),
		.kin (kin),
		.key (pipe_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nk_sum_q   <= '0;
			seed_q     <= '0;
			hk1_q      <= '0;
			hk2_q      <= '0;
			dec_en_q   <= 1'b1;
			fidx_sum_q <= '0;
			size_q     <= '0;
			name_cnt_q <= '0;
			name_sum_q <= '0;
			data_cnt_q <= '0;
			file_key_q <= '0;
			key_rdy_q  <= 1'b0;
			settle_q   <= 1'b1;
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			settle_q <= cfg_acc || (s1_move && name_s1) ||
				(in_acc && ((func == FUNC_START) || (func == FUNC_NAME)));

			if (cfg_acc) begin
				unique case (cfg_index)
					REG_NAME_KEY:  nk_sum_q <= byte_sum(cfg_data);
					REG_DATA_SEED: seed_q   <= cfg_data[7:0];
					REG_HDR_ONE:   hk1_q    <= cfg_data[7:0];
					REG_HDR_TWO:   hk2_q    <= cfg_data[7:0];
					REG_DEC_EN:    dec_en_q <= cfg_data[0];
					default: ;
				endcase
			end

			// a start clears the sum even while stage one retires a name
			if (in_acc && (func == FUNC_START)) begin
				name_sum_q <= '0;
			end else if (s1_move && name_s1) begin
				name_sum_q <= name_sum_q + name_dec;
			end
			if (s1_move && !name_s1 && new_key_s1) begin
				file_key_q <= pipe_key;
			end

			if (in_acc) begin
				unique case (func)
					FUNC_LOAD: ;
					FUNC_START: begin
						fidx_sum_q <= byte_sum(file_index);
						size_q     <= original_size[7:0];
						name_cnt_q <= '0;
						data_cnt_q <= '0;
						key_rdy_q  <= 1'b0;
					end
					FUNC_NAME: begin
						if (name_cnt_q != NC_SAT) begin
							name_cnt_q <= name_cnt_q + 1'b1;
						end
					end
					FUNC_DATA: begin
						key_rdy_q <= 1'b1;
						if (data_cnt_q != DC_SAT) begin
							data_cnt_q <= data_cnt_q + 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (in_acc && ((func == FUNC_NAME) || (func == FUNC_DATA))) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end

			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_sum_q <= nk_sum_q + fidx_sum_q;
		if (in_acc) begin
			name_s1    <= (func == FUNC_NAME);
			byte_s1    <= byte_value;
			pos_s1     <= nc_ext[7:0];
			cnt_s1     <= dc_ext[7:0];
			enc_s1     <= enc;
			new_key_s1 <= !key_rdy_q;
		end
		if (s1_move) begin
			out_byte_q <= name_s1 ? name_dec : data_dec;
			out_name_q <= name_s1;
		end
	end

	assign out_valid = out_v_q;
	assign byte_out  = out_byte_q;
	assign from_name = out_name_q;
endmodule

// File: sv/nkbd_checker.sv
// Port-level checks of the descrambler, bound to the top level.
// Depends on nkbd_pkg and name_keyed_byte_descrambler_defines.svh.
`include "name_keyed_byte_descrambler_defines.svh"

module nkbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic       from_name
);
	import nkbd_pkg::*;

	logic out_stall;
	logic word_acc;

	assign out_stall = out_valid && !out_ready;
	assign word_acc  = in_valid && in_ready && ((func == FUNC_NAME) || (func == FUNC_DATA));

	// a stalled output word holds
	`NKBD_ASSERT(a_out_hold, clk, arst_n, out_stall |=> out_valid && $stable(byte_out) && $stable(from_name))

	// a fresh word comes from a name or data item that passed through stage one into the output register
	`NKBD_ASSERT(a_out_src, clk, arst_n, $rose(out_valid) |-> $past(word_acc, 2))

	// nothing is offered while reset is held
	`NKBD_ASSERT_NR(a_rst_quiet, clk, !arst_n |-> !out_valid)
endmodule

bind name_keyed_byte_descrambler nkbd_checker u_nkbd_checker (.*);

// File: sim/tb_name_keyed_byte_descrambler.sv
`timescale 1ns / 100ps
// Self-checking bench for name_keyed_byte_descrambler: random and directed streams with a
// tracking model of table, name and data keys. Depends on nkbd_pkg and the block's RTL.
module tb_name_keyed_byte_descrambler;
	import nkbd_pkg::*;

	localparam int unsigned SPAN          = ENCRYPTED_SPAN_DEF;
	localparam int unsigned NAME_CAP      = NAME_LEN_MAX_DEF;
	localparam int unsigned RANDOM_ITEMS  = 820;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic [7:0] value;
		logic       from_name;
	} byte_word_t;

	class byte_key_tracker;
		logic [31:0] name_word, seed_word, hdr_one, hdr_two;
		logic        decrypt_on;
		logic [7:0]  subst [256];
		logic [31:0] entry_pos;
		logic [7:0]  size_byte, name_total, entry_key;
		int unsigned name_len, data_len;
		bit          key_held;
		byte_word_t  awaited [$];
		int unsigned errors, names, datas, clear_datas, starts, loads, reg_writes;

		function new();
			name_word  = '0;
			seed_word  = '0;
			hdr_one    = '0;
			hdr_two    = '0;
			decrypt_on = 1'b1;
			foreach (subst[i])
				subst[i] = 8'h00;
			entry_pos  = '0;
			size_byte  = '0;
			name_total = '0;
			entry_key  = '0;
			name_len   = 0;
			data_len   = 0;
			key_held   = 0;
			errors     = 0;
			names      = 0;
			datas      = 0;
			clear_datas = 0;
			starts     = 0;
			loads      = 0;
			reg_writes = 0;
		endfunction

		static function logic [7:0] lane_sum(input logic [31:0] w);
			return w[7:0] + w[15:8] + w[23:16] + w[31:24];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(input string what);
			if (errors < 50)
				$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		function void set_reg(input cfg_reg_t r, input logic [31:0] d);
			reg_writes++;
			case (r)
			REG_NAME_KEY:  name_word  = d;
			REG_DATA_SEED: seed_word  = d;
			REG_HDR_ONE:   hdr_one    = d;
			REG_HDR_TWO:   hdr_two    = d;
			REG_DEC_EN:    decrypt_on = d[0];
			default: ;
			endcase
		endfunction

		function void take_item(input func_t f, input logic [7:0] b, input logic [7:0] ti,
				input logic [31:0] fi, input logic [31:0] os);
			logic [7:0] pos;
			logic [7:0] outb;
			case (f)
			FUNC_LOAD: begin
				subst[ti] = b;
				loads++;
			end
			FUNC_START: begin
				entry_pos  = fi;
				size_byte  = os[7:0];
				name_total = '0;
				name_len   = 0;
				data_len   = 0;
				entry_key  = '0;
				key_held   = 0;
				starts++;
			end
			FUNC_NAME: begin
				pos = 8'(name_len);
				outb = b + NAME_KEY_MULT * pos - lane_sum(name_word) - lane_sum(entry_pos);
				name_total = name_total + outb;
				// saturate, later bytes keep the last position
				if (name_len < NAME_CAP)
					name_len++;
				awaited.push_back('{value: outb, from_name: 1'b1});
				names++;
			end
			default: begin
				if (!key_held) begin
					entry_key = seed_word[7:0] - name_total;
					entry_key = entry_key * 8'(name_len);
					entry_key = entry_key + hdr_one[7:0] * hdr_two[7:0];
					entry_key = entry_key * size_byte;
					key_held  = 1;
				end
				if (decrypt_on && data_len < SPAN + name_len) begin
					outb = subst[b] - entry_key - 8'(data_len);
				end else begin
					outb = b;
					clear_datas++;
				end
				if (data_len < SPAN + NAME_CAP)
					data_len++;
				awaited.push_back('{value: outb, from_name: 1'b0});
				datas++;
			end
			endcase
		endfunction

		task match_word(input logic [7:0] v, input logic nf);
			byte_word_t want;
			if (awaited.size() == 0) begin
				report($sformatf("word %02h from_name=%0b with nothing awaited", v, nf));
				return;
			end
			want = awaited.pop_front();
			if (v !== want.value)
				report($sformatf("byte_out %02h, awaited %02h", v, want.value));
			if (nf !== want.from_name)
				report($sformatf("from_name %0b, awaited %0b", nf, want.from_name));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  byte_value;
	logic [7:0]  table_index;
	logic [31:0] file_index;
	logic [31:0] original_size;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte_out;
	logic        from_name;

	bit          calm;
	int unsigned cycle_count = 0;
	byte_key_tracker book = new();

	name_keyed_byte_descrambler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.byte_value(byte_value),
		.table_index(table_index),
		.file_index(file_index),
		.original_size(original_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_out(byte_out),
		.from_name(from_name)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("name_keyed_byte_descrambler regression: fail");
			$finish;
		end
	end

	// receiver stalls at random except in the calm stretch
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 26);

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				book.match_word(byte_out, from_name);
			if (cfg_valid && cfg_ready)
				book.set_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && in_ready)
				book.take_item(func_t'(func), byte_value, table_index, file_index,
					original_size);
		end
	end

	// Call at a falling edge; returns at the falling edge after the word is taken,
	// with valid still high.
	task automatic send(input func_t f, input logic [7:0] b, input logic [7:0] ti,
			input logic [31:0] fi, input logic [31:0] os);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		byte_value    <= b;
		table_index   <= ti;
		file_index    <= fi;
		original_size <= os;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_load(input logic [7:0] ti, input logic [7:0] b);
		send(FUNC_LOAD, b, ti, $urandom, $urandom);
	endtask

	task automatic send_start(input logic [31:0] fi, input logic [31:0] os);
		send(FUNC_START, 8'($urandom), 8'($urandom), fi, os);
	endtask

	task automatic send_name(input logic [7:0] b);
		send(FUNC_NAME, b, 8'($urandom), $urandom, $urandom);
	endtask

	task automatic send_data(input logic [7:0] b);
		send(FUNC_DATA, b, 8'($urandom), $urandom, $urandom);
	endtask

	// Drop valid, drain every awaited word, then let the key pipe go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] nk, input logic [31:0] seed,
			input logic [31:0] h1, input logic [31:0] h2, input logic en);
		write_reg(REG_NAME_KEY, nk);
		write_reg(REG_DATA_SEED, seed);
		write_reg(REG_HDR_ONE, h1);
		write_reg(REG_HDR_TWO, h2);
		write_reg(REG_DEC_EN, {31'd0, en});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
		0:       return 32'h0000_0000;
		1:       return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned fed;
		int unsigned next_regs;
		int unsigned nlen;
		int unsigned dlen;
		int unsigned pick;

		arst_n        = 1'b0;
		calm          = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_NAME_KEY;
		cfg_data      = '0;
		in_valid      = 1'b0;
		func          = FUNC_LOAD;
		byte_value    = '0;
		table_index   = '0;
		file_index    = '0;
		original_size = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the whole table so no data byte reads an unloaded entry
		for (int i = 0; i < 256; i++)
			send_load(8'(i), (i == 0) ? 8'hff : (i == 255) ? 8'h00 : 8'($urandom));

		// data and name words before any start, reset registers
		send_data(8'h00);
		send_data(8'hff);
		send_name(8'h5a);
		send_data(8'h33);

		settle();
		set_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_start(32'hffff_ffff, 32'hffff_ffff);
		send_name(8'h00);
		send_name(8'hff);
		send_data(8'h00);
		send_data(8'hff);
		// name after the key is formed: key holds, span widens
		send_name(8'h80);
		send_data(8'h7f);

		// decryption off, key still formed on the first data byte
		settle();
		set_regs(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		send_data(8'hc3);
		send_start(32'h0, 32'h0);
		send_name(8'h01);
		send_data(8'h10);

		// new registers mid-file must not touch the key already formed
		settle();
		set_regs(pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
		send_data(8'h20);
		send_start($urandom, 32'h0000_00ff);
		send_name(8'($urandom));
		send_data(8'($urandom));

		fed = 0;
		next_regs = 0;
		while (fed < RANDOM_ITEMS) begin
			calm = (fed >= 300 && fed < 550);
			if (fed >= next_regs) begin
				settle();
				set_regs(pick_word(), pick_word(), pick_word(), pick_word(),
					$urandom_range(3) != 0);
				next_regs = fed + 220;
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_start(pick_word(), pick_word());
				nlen = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(12);
				dlen = $urandom_range(30);
				repeat (nlen) send_name(8'($urandom));
				repeat (dlen) send_data(8'($urandom));
				fed += 1 + nlen + dlen;
			end else if (pick < 80) begin
				send_load(8'($urandom), 8'($urandom));
				fed++;
			end else if (pick < 90) begin
				send_name(8'($urandom));
				fed++;
			end else begin
				send_data(8'($urandom));
				fed++;
			end
		end
		calm = 1'b0;

		settle();
		$display("covered %0d name and %0d data words (%0d passed in clear), %0d starts,",
			book.names, book.datas, book.clear_datas, book.starts);
		$display("%0d table loads and %0d register writes", book.loads, book.reg_writes);
		if (book.errors == 0)
			$display("name_keyed_byte_descrambler regression: pass");
		else
			$display("name_keyed_byte_descrambler regression: fail");
		$finish;
	end

endmodule
